/* hdl/mlpr_pkg.sv */
package mlpr_pkg;

   localparam int DATA_W        = 16;
   localparam int CH_W          = 3;
   localparam int COEF_W        = 16;
   localparam int FRAC_BITS     = 13;
   localparam int PROD_W        = DATA_W + COEF_W + 1;
   localparam int ACC_W         = FRAC_BITS + DATA_W;
   localparam int NUM_COEF_REGS = 5;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int GROUP_SIZE    = 4;
   localparam int DEF_CHANNELS  = 8;
   localparam int DEF_TAPS      = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_0 = 3'd0,
      CSR_COEF_1 = 3'd1,
      CSR_COEF_2 = 3'd2,
      CSR_COEF_3 = 3'd3,
      CSR_COEF_4 = 3'd4
   } csr_idx_type;

   localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEF_REGS] = '{
      -16'sd2949, 16'sd5816, -16'sd4669, -16'sd5325, 16'sd13517
   };

   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic [DATA_W-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]   channel_out;
      logic [DATA_W-1:0] residual;
   } rsp_type;

   typedef struct packed {
      logic prod_en;
      logic part_en;
      logic sum_en;
   } mac_ctl_type;

endpackage

/* hdl/multichannel_linear_prediction_residual_core.sv */
// Per-channel linear prediction residual. Each beat on req carries a channel
// and a 16-bit sample; one rsp beat per request returns the channel and the
// prediction (Q2.13 weighted sum of that channel's last TAPS samples, floored)
// minus the sample, modulo 2^16. One sample is taken every cycle, including
// back-to-back samples of the same channel, unless the pipeline is full and
// rsp is stalled. The histories sit in a CHANNELS-row memory, one row per
// channel, read when a request is taken and written back as it leaves the
// first stage; per-row valid bits make every history read as zero after
// reset, with no clearing pass. Channels at or above CHANNELS predict zero
// and leave the histories alone. Coefficient writes on the csr port belong
// in idle periods.
module multichannel_linear_prediction_residual_core import mlpr_pkg::*; #(
   parameter int CHANNELS = DEF_CHANNELS,
   parameter int TAPS     = DEF_TAPS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_W  = ($clog2(CHANNELS + 1) > CH_W) ? $clog2(CHANNELS + 1) : CH_W;

   logic signed [COEF_W-1:0]    coef_ff [NUM_COEF_REGS];
   logic [TAPS-1:0][COEF_W-1:0] tap_coef;

   logic                        stg1_vld_ff, stg2_vld_ff, stg3_vld_ff, stg4_vld_ff;
   logic                        rsp_vld_ff;
   logic [CH_W-1:0]             stg1_ch_ff, stg2_ch_ff, stg3_ch_ff, stg4_ch_ff;
   logic [DATA_W-1:0]           stg1_smp_ff, stg2_smp_ff, stg3_smp_ff, stg4_smp_ff;
   logic                        stg1_inr_ff;
   rsp_type                     rsp_data_ff;

   logic                        out_rdy, stg4_rdy, stg3_rdy, stg2_rdy, stg1_rdy;
   logic                        req_acc, rsp_acc;
   logic                        req_inr;
   logic [TAPS-1:0][DATA_W-1:0] hist_row, cur_row, new_row;
   logic                        hist_wr_en;
   mac_ctl_type                 mac_ctl;
   logic [ACC_W-1:0]            sum;
   logic [DATA_W-1:0]           residual;
   logic [2:0]                  occ;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= COEF_RESET;
      end else if (csr_write_en && (csr_index <= CSR_COEF_4) && (csr_index < TAPS)) begin
         coef_ff[csr_index] <= csr_data;
      end
   end

   for (genvar k = 0; k < TAPS; k++) begin : g_coef
      if (k < NUM_COEF_REGS) begin : g_reg
         assign tap_coef[k] = coef_ff[k];
      end else begin : g_zero
         assign tap_coef[k] = '0;
      end
   end

   assign out_rdy   = !rsp_vld_ff || !rsp_stall;
   assign stg4_rdy  = !stg4_vld_ff || out_rdy;
   assign stg3_rdy  = !stg3_vld_ff || stg4_rdy;
   assign stg2_rdy  = !stg2_vld_ff || stg3_rdy;
   assign stg1_rdy  = !stg1_vld_ff || stg2_rdy;
   assign req_stall = !stg1_rdy;
   assign req_acc   = req_valid && stg1_rdy;
   assign rsp_acc   = rsp_vld_ff && !rsp_stall;
   assign req_inr   = CMP_W'(req_data.channel) < CMP_W'(CHANNELS);

   assign mac_ctl.prod_en = stg1_vld_ff && stg2_rdy;
   assign mac_ctl.part_en = stg2_vld_ff && stg3_rdy;
   assign mac_ctl.sum_en  = stg3_vld_ff && stg4_rdy;

   assign hist_wr_en = mac_ctl.prod_en && stg1_inr_ff;
   assign cur_row    = stg1_inr_ff ? hist_row : '0;

   // drop the oldest sample, append the new one
   if (TAPS > 1) begin : g_shift
      assign new_row = {stg1_smp_ff, cur_row[TAPS-1:1]};
   end else begin : g_single
      assign new_row = stg1_smp_ff;
   end

   mlpr_hist #(
      .CHANNELS (CHANNELS),
      .TAPS     (TAPS),
      .ADDR_W   (ADDR_W)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_acc),
      .rd_addr (ADDR_W'(req_data.channel)),
      .wr_en   (hist_wr_en),
      .wr_addr (ADDR_W'(stg1_ch_ff)),
      .wr_row  (new_row),
      .rd_row  (hist_row)
   );

   mlpr_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .row    (cur_row),
      .coef   (tap_coef),
      .sum_ff (sum)
   );

   assign residual = sum[ACC_W-1:FRAC_BITS] - stg4_smp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg1_vld_ff <= 1'b0;
         stg2_vld_ff <= 1'b0;
         stg3_vld_ff <= 1'b0;
         stg4_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (stg1_rdy) begin
            stg1_vld_ff <= req_valid;
         end
         if (stg2_rdy) begin
            stg2_vld_ff <= stg1_vld_ff;
         end
         if (stg3_rdy) begin
            stg3_vld_ff <= stg2_vld_ff;
         end
         if (stg4_rdy) begin
            stg4_vld_ff <= stg3_vld_ff;
         end
         if (out_rdy) begin
            rsp_vld_ff <= stg4_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         stg1_ch_ff  <= req_data.channel;
         stg1_smp_ff <= req_data.sample_value;
         stg1_inr_ff <= req_inr;
      end
      if (mac_ctl.prod_en) begin
         stg2_ch_ff  <= stg1_ch_ff;
         stg2_smp_ff <= stg1_smp_ff;
      end
      if (mac_ctl.part_en) begin
         stg3_ch_ff  <= stg2_ch_ff;
         stg3_smp_ff <= stg2_smp_ff;
      end
      if (mac_ctl.sum_en) begin
         stg4_ch_ff  <= stg3_ch_ff;
         stg4_smp_ff <= stg3_smp_ff;
      end
      if (stg4_vld_ff && out_rdy) begin
         rsp_data_ff.channel_out <= stg4_ch_ff;
         rsp_data_ff.residual    <= residual;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   assign occ = 3'($countones({stg1_vld_ff, stg2_vld_ff, stg3_vld_ff, stg4_vld_ff,
                               rsp_vld_ff}));

   a_occ_up: assert property (@(posedge clock) disable iff (reset)
      !reset && req_acc && !rsp_acc |=> occ == $past(occ) + 3'd1)
      else $error("beat count did not grow on an accepted request");

   a_occ_down: assert property (@(posedge clock) disable iff (reset)
      !reset && !req_acc && rsp_acc |=> occ == $past(occ) - 3'd1)
      else $error("beat count did not shrink on a delivered result");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stg1_vld_ff && stg2_vld_ff && stg3_vld_ff && stg4_vld_ff
                    && rsp_vld_ff && rsp_stall)
      else $error("request stalled while the pipeline has a free slot");

endmodule

/* hdl/mlpr_hist.sv */
module mlpr_hist import mlpr_pkg::*; #(
   parameter int CHANNELS = DEF_CHANNELS,
   parameter int TAPS     = DEF_TAPS,
   parameter int ADDR_W   = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [TAPS-1:0][DATA_W-1:0]  wr_row,
   output logic [TAPS-1:0][DATA_W-1:0]  rd_row
);

   logic [TAPS-1:0][DATA_W-1:0] mem [CHANNELS];
   logic [CHANNELS-1:0]         row_vld_ff;
   logic [TAPS-1:0][DATA_W-1:0] mem_q_ff;
   logic [TAPS-1:0][DATA_W-1:0] fwd_row_ff;
   logic                        mem_vld_ff;
   logic                        fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         mem_q_ff   <= mem[rd_addr];
         fwd_row_ff <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         mem_vld_ff <= 1'b0;
         fwd_ff     <= 1'b0;
      end else begin
         if (wr_en) begin
            row_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            mem_vld_ff <= row_vld_ff[rd_addr];
            fwd_ff     <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   // take the row being written in the same cycle as the read
   assign rd_row = fwd_ff ? fwd_row_ff : (mem_vld_ff ? mem_q_ff : '0);

endmodule

/* hdl/mlpr_mac.sv */
module mlpr_mac import mlpr_pkg::*; #(
   parameter int TAPS = DEF_TAPS
) (
   input  logic                         clock,
   input  mac_ctl_type                  ctl,
   input  logic [TAPS-1:0][DATA_W-1:0]  row,
   input  logic [TAPS-1:0][COEF_W-1:0]  coef,
   output logic [ACC_W-1:0]             sum_ff
);

   localparam int GROUPS = (TAPS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int SLOTS  = GROUPS * GROUP_SIZE;

   logic [ACC_W-1:0] prod_in  [SLOTS];
   logic [ACC_W-1:0] prod_ff  [SLOTS];
   logic [ACC_W-1:0] part_in  [GROUPS];
   logic [ACC_W-1:0] part_ff  [GROUPS];
   logic [ACC_W-1:0] sum_in;

   // only the low ACC_W bits reach the residual, so accumulate modulo 2^ACC_W
   for (genvar k = 0; k < SLOTS; k++) begin : g_prod
      if (k < TAPS) begin : g_tap
         logic signed [PROD_W-1:0] full_prod;
         assign full_prod = PROD_W'($signed({1'b0, row[k]}))
                          * PROD_W'($signed(coef[k]));
         assign prod_in[k] = full_prod[ACC_W-1:0];
      end else begin : g_pad
         assign prod_in[k] = '0;
      end
   end

   for (genvar g = 0; g < GROUPS; g++) begin : g_part
      always_comb begin
         part_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            part_in[g] = part_in[g] + prod_ff[g * GROUP_SIZE + j];
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         sum_in = sum_in + part_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.part_en) begin
         part_ff <= part_in;
      end
      if (ctl.sum_en) begin
         sum_ff <= sum_in;
      end
   end

endmodule
